// ===== hw/rtl/urr_pkg.sv =====
`timescale 1ns / 1ps

package urr_pkg;

  // Generator state and request data widths
  localparam int STATE_W = 48;
  localparam int DATA_W  = 32;
  localparam int DRAW_W  = 31;
  localparam int DRAW_LSB = STATE_W - DRAW_W;

  // drand48 recurrence constants
  localparam int MULT_W = 35;
  localparam logic [MULT_W-1:0]  LCG_MULT = 35'h5DEECE66D;
  localparam logic [STATE_W-1:0] LCG_INC  = 48'hB;

  // State is multiplied in chunks, one chunk per cycle
  localparam int CHUNK_W    = 16;
  localparam int NUM_CHUNKS = STATE_W / CHUNK_W;
  localparam int CHUNK_IDX_W = $clog2(NUM_CHUNKS);
  localparam int PROD_W     = CHUNK_W + MULT_W;

  // Remainder unit retires one dividend bit per cycle
  localparam int DIV_CNT_W = $clog2(DATA_W);

endpackage

// ===== hw/rtl/uniform_range_random_unit.sv =====
`timescale 1ns / 1ps

// Path: an inverted range goes straight to the output register; the full 32-bit span skips
//   the threshold; other ranges run threshold, draw, check and modulo, redrawing on each reject.
// Throughput: one request at a time; the input stalls until the result is registered.
//   The one-bit-per-cycle remainder unit (used for threshold and final modulo) sets it.
// Reset: synchronous active high; generator state returns to seed 0, output empties.
module uniform_range_random_unit (
  input  logic                          clk,
  input  logic                          rst,
  // seed register write port
  input  logic                          seed_write,
  input  logic [urr_pkg::STATE_W-1:0]   seed_data,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [urr_pkg::DATA_W-1:0]    range_low,
  input  logic [urr_pkg::DATA_W-1:0]    range_high,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [urr_pkg::DATA_W-1:0]    value,
  output logic                          range_error
);

  typedef enum logic [2:0] {
    S_IDLE,    // wait for a request, take seed writes
    S_THRESH,  // remainder unit: (2^32 - span) mod span
    S_DRAW,    // chunked multiply advances the generator
    S_CHECK,   // rejection test on the fresh draw
    S_MOD,     // remainder unit: draw mod span
    S_DONE     // hand result to the output register
  } state_t;

  localparam logic [urr_pkg::DIV_CNT_W-1:0]   DIV_LAST = urr_pkg::DIV_CNT_W'(urr_pkg::DATA_W - 1);
  localparam logic [urr_pkg::CHUNK_IDX_W-1:0] MUL_LAST =
    urr_pkg::CHUNK_IDX_W'(urr_pkg::NUM_CHUNKS - 1);

  state_t                            state;
  logic [urr_pkg::STATE_W-1:0]       lcg_state;
  logic [urr_pkg::STATE_W-1:0]       acc;
  logic [urr_pkg::CHUNK_IDX_W-1:0]   mul_idx;
  logic [urr_pkg::DATA_W-1:0]        lo;
  logic [urr_pkg::DATA_W-1:0]        span;
  logic [urr_pkg::DATA_W-1:0]        thresh;
  logic [urr_pkg::DRAW_W-1:0]        draw;
  logic [urr_pkg::DATA_W-1:0]        div_shift;
  logic [urr_pkg::DATA_W-1:0]        div_rem;
  logic [urr_pkg::DIV_CNT_W-1:0]     div_cnt;
  logic [urr_pkg::DATA_W-1:0]        res_value;
  logic                              res_error;

  logic [urr_pkg::DATA_W-1:0]        span_in;
  logic [urr_pkg::DATA_W:0]          trial;
  logic [urr_pkg::DATA_W-1:0]        div_rem_next;
  logic [urr_pkg::CHUNK_W-1:0]       chunk;
  logic [urr_pkg::PROD_W-1:0]        partial;
  logic [urr_pkg::STATE_W-1:0]       acc_next;

  // Span wraps to 0 for the full 32-bit range
  assign span_in = range_high - range_low + urr_pkg::DATA_W'(1);

  // Hold the request side off for the whole life of an item
  assign in_stall = (state != S_IDLE);

  // Shared restoring remainder step: shift in one dividend bit, subtract span if it fits.
  // The running remainder stays below span, so the trial fits in one extra bit.
  assign trial = {div_rem, div_shift[urr_pkg::DATA_W-1]};
  always_comb begin
    if (trial >= {1'b0, span}) begin
      div_rem_next = urr_pkg::DATA_W'(trial - {1'b0, span});
    end else begin
      div_rem_next = trial[urr_pkg::DATA_W-1:0];
    end
  end

  // Generator multiply: one 16-bit chunk of the state times the multiplier per cycle,
  // truncated to 48 bits, then shifted into place and accumulated.
  assign chunk    = lcg_state[urr_pkg::CHUNK_W*mul_idx +: urr_pkg::CHUNK_W];
  assign partial  = {{urr_pkg::MULT_W{1'b0}}, chunk} *
                    {{urr_pkg::CHUNK_W{1'b0}}, urr_pkg::LCG_MULT};
  assign acc_next = acc + (urr_pkg::STATE_W'(partial) << (urr_pkg::CHUNK_W * mul_idx));

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      lcg_state   <= '0;
      out_valid   <= 1'b0;
    end else begin
      // load a finished result when the output register is free or being emptied,
      // drop it once the consumer takes the transfer
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (seed_write) begin
            lcg_state <= seed_data;
          end
          if (in_valid) begin
            lo        <= range_low;
            span      <= span_in;
            if (range_low > range_high) begin
              // inverted range: flag it and leave the generator alone
              res_value <= '0;
              res_error <= 1'b1;
              state     <= S_DONE;
            end else begin
              res_error <= 1'b0;
              div_shift <= urr_pkg::DATA_W'(0) - span_in;
              div_rem   <= '0;
              div_cnt   <= '0;
              acc       <= urr_pkg::LCG_INC;
              mul_idx   <= '0;
              // full span needs no threshold
              state     <= (span_in == '0) ? S_DRAW : S_THRESH;
            end
          end
        end

        S_THRESH: begin
          div_rem   <= div_rem_next;
          div_shift <= div_shift << 1;
          div_cnt   <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            thresh <= div_rem_next;
            state  <= S_DRAW;
          end
        end

        S_DRAW: begin
          acc     <= acc_next;
          mul_idx <= mul_idx + 1'b1;
          if (mul_idx == MUL_LAST) begin
            mul_idx   <= '0;
            lcg_state <= acc_next;
            draw      <= acc_next[urr_pkg::STATE_W-1:urr_pkg::DRAW_LSB];
            state     <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (span == '0) begin
            res_value <= lo + {1'b0, draw};
            state     <= S_DONE;
          end else if ({1'b0, draw} < thresh) begin
            // reject and draw again
            acc     <= urr_pkg::LCG_INC;
            mul_idx <= '0;
            state   <= S_DRAW;
          end else begin
            div_shift <= {1'b0, draw};
            div_rem   <= '0;
            div_cnt   <= '0;
            state     <= S_MOD;
          end
        end

        S_MOD: begin
          div_rem   <= div_rem_next;
          div_shift <= div_shift << 1;
          div_cnt   <= div_cnt + 1'b1;
          if (div_cnt == DIV_LAST) begin
            res_value <= lo + div_rem_next;
            state     <= S_DONE;
          end
        end

        S_DONE: begin
          // advance only when the output register is free or being emptied
          if (!out_valid || !out_stall) begin
            value       <= res_value;
            range_error <= res_error;
            state       <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An inverted range must not move the generator
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && (range_low > range_high) && !seed_write)
      |=> (lcg_state == $past(lcg_state)))
    else $error("generator state changed on inverted range");

  // The remainder unit must end below the divisor
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_MOD) && (div_cnt == DIV_LAST)) |=> (div_rem < span))
    else $error("remainder not below span");

  // A threshold is always below the span it was taken from
  assert property (@(posedge clk) disable iff (rst)
    ((state == S_THRESH) && (div_cnt == DIV_LAST)) |=> (thresh < span))
    else $error("rejection threshold not below span");

  // A new result is only loaded out of the done state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_DONE))
    else $error("result appeared outside the done state");

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int DATA_W  = urr_pkg::DATA_W;
  localparam int STATE_W = urr_pkg::STATE_W;

  // Recurrence of the drand48 family, kept mod 2^48 by the vector width
  localparam logic [STATE_W-1:0] MULTIPLIER = 48'h5_DEEC_E66D;
  localparam logic [STATE_W-1:0] INCREMENT  = 48'hB;

  // Random ranges that would need more draws than this are re-picked
  localparam int REJECT_CAP     = 256;
  localparam int NO_CAP         = 32'h3FFF_FFFF;
  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 200;
  localparam int WATCHDOG_LIMIT = 200000;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              range_error;
    logic [DATA_W-1:0] req_low;
    logic [DATA_W-1:0] req_high;
  } range_result_t;

  logic               clk;
  logic               rst;
  logic               seed_write;
  logic [STATE_W-1:0] seed_data;
  logic               in_valid;
  logic               in_stall;
  logic [DATA_W-1:0]  range_low;
  logic [DATA_W-1:0]  range_high;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DATA_W-1:0]  value;
  logic               range_error;

  // Shadow of the generator state; follows every accepted request and seed write
  logic [STATE_W-1:0] shadow_lcg = '0;
  range_result_t      expected_results[$];
  range_result_t      oldest_result;

  int  mismatch_count = 0;
  int  quiet_cycles   = 0;
  bit  idle_enable    = 1'b1;
  int  hold_requests_made   = 0;
  int  hold_requests_served = 0;
  int  rx_hold_left   = 0;
  int  rx_burst_left  = 0;

  uniform_range_random_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .seed_write  (seed_write),
    .seed_data   (seed_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .range_low   (range_low),
    .range_high  (range_high),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .value       (value),
    .range_error (range_error)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Advance the generator until a draw clears the rejection floor, then fold it
  // into the range. A wrapped span (full 32-bit range) takes the first draw as is.
  // Give up once draws exceeds cap; draws then reports cap + 1 and the result may be junk.
  task automatic roll_range(inout logic [STATE_W-1:0] st,
                            input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi,
                            input int cap, output range_result_t res, output int draws);
    logic [DATA_W-1:0] span;
    logic [DATA_W-1:0] floor_v;
    logic [DATA_W-1:0] draw;
    res.value       = '0;
    res.range_error = 1'b0;
    res.req_low     = lo;
    res.req_high    = hi;
    draws           = 0;
    if (lo > hi) begin
      // inverted range: flag it and leave the generator alone
      res.range_error = 1'b1;
    end else begin
      span = hi - lo + 32'd1;
      if (span == 32'd0) begin
        floor_v = '0;
      end else begin
        floor_v = (32'd0 - span) % span;
      end
      do begin
        st    = st * MULTIPLIER + INCREMENT;
        draw  = {1'b0, st[STATE_W-1:STATE_W-31]};
        draws = draws + 1;
      end while (draw < floor_v && draws <= cap);
      if (span == 32'd0) begin
        res.value = lo + draw;
      end else begin
        res.value = lo + draw % span;
      end
    end
  endtask

  // Pick a random range; mostly well-formed ranges of many shapes, some inverted.
  // Re-pick anything whose rejection run from the current state would be too long.
  task automatic pick_range(output logic [DATA_W-1:0] lo, output logic [DATA_W-1:0] hi);
    logic [STATE_W-1:0] trial;
    logic [DATA_W-1:0]  a;
    logic [DATA_W-1:0]  b;
    logic [DATA_W-1:0]  span;
    range_result_t      r;
    int                 n;
    n = REJECT_CAP + 1;
    while (n > REJECT_CAP) begin
      a = $urandom;
      b = $urandom;
      case ($urandom_range(0, 9))
        0: begin
          // inverted: larger bound first
          lo = (a > b) ? a : b;
          hi = (a > b) ? b : a;
        end
        1: begin
          if ($urandom_range(0, 1) == 0) begin
            lo = '0;
            hi = '1;
          end else begin
            lo = $urandom_range(0, 3);
            hi = 32'hFFFF_FFFF - $urandom_range(0, 3);
          end
        end
        2: begin
          lo = a;
          hi = a;
        end
        3, 4, 5: begin
          // narrow span anywhere; a wrap past the top becomes an inverted range
          lo = a;
          hi = a + $urandom_range(1, 255);
        end
        6: begin
          span = (32'd1 << $urandom_range(1, 31)) + $urandom_range(0, 2) - 32'd1;
          lo   = $urandom_range(0, 32'hFFFF_FFFF - span + 32'd1);
          hi   = lo + span - 32'd1;
        end
        default: begin
          lo = (a > b) ? b : a;
          hi = (a > b) ? a : b;
        end
      endcase
      trial = shadow_lcg;
      roll_range(trial, lo, hi, REJECT_CAP, r, n);
    end
  endtask

  // Offer one request, maybe after a random gap, and log its result on transfer
  task automatic send_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    range_result_t r;
    int            n;
    @(negedge clk);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid   = 1'b1;
    range_low  = lo;
    range_high = hi;
    do @(posedge clk); while (in_stall);
    roll_range(shadow_lcg, lo, hi, NO_CAP, r, n);
    expected_results.push_back(r);
  endtask

  task automatic send_random(input int count);
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    repeat (count) begin
      pick_range(lo, hi);
      send_range(lo, hi);
    end
  endtask

  // Drop valid and hold until every logged result has come back
  task automatic wait_results_drained;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Seed writes happen only with the unit idle; a write reloads the generator
  task automatic write_seed(input logic [STATE_W-1:0] s);
    wait_results_drained();
    @(negedge clk);
    seed_write = 1'b1;
    seed_data  = s;
    @(negedge clk);
    seed_write = 1'b0;
    shadow_lcg = s;
  endtask

  // Bounds at the extremes, every shape of span, inverted and wrapped ranges
  task automatic test_directed_ranges;
    send_range(32'h0000_0000, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0001, 32'h0000_0000);
    send_range(32'hFFFF_FFFF, 32'h0000_0000);
    send_range(32'h8000_0000, 32'h7FFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_0001);
    send_range(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h7FFF_FFFF);
    send_range(32'h0000_0001, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFE);
    send_range(32'h1234_5678, 32'h9ABC_DEF0);
  endtask

  // Seed register at all ones and at single set bits
  task automatic test_seed_extremes;
    write_seed(48'hFFFF_FFFF_FFFF);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    send_range(32'h0000_0000, 32'h0000_FFFF);
    send_range(32'h0000_0005, 32'h0000_0004);
    send_range(32'hAAAA_AAAA, 32'hAAAA_AAB9);
    write_seed(48'h0000_0000_0001);
    send_range(32'h0000_0000, 32'h0000_0002);
    send_range(32'h0000_0000, 32'hFFFF_FFFF);
    write_seed(48'h8000_0000_0000);
    send_range(32'h5555_5555, 32'h5555_5555);
    send_range(32'h0000_0000, 32'h0000_FFFF);
  endtask

  // Spans just above 2^31 reject most draws; keep them far enough above to finish
  task automatic test_long_rejection;
    send_range(32'h0000_0000, 32'h803F_FFFF);
    send_range(32'h1000_0000, 32'h93FF_FFFF);
    send_range(32'h0000_0000, 32'hAAAA_AAAA);
  endtask

  // Block the result port for a long stretch while requests keep coming,
  // then pause the requests until everything is back and send one more batch
  task automatic test_backpressure;
    hold_requests_made = hold_requests_made + 1;
    send_random(8);
    wait_results_drained();
    send_random(20);
  endtask

  // Several seeds, the extremes among them; the last stretch runs with no idling
  task automatic test_random_ranges;
    write_seed({16'($urandom), 32'($urandom)});
    send_random(300);
    write_seed(48'hFFFF_FFFF_FFFF);
    send_random(250);
    write_seed(48'h0000_0000_0000);
    send_random(250);
    write_seed({16'($urandom), 32'($urandom)});
    send_random(300);
    idle_enable = 1'b0;
    send_random(200);
  endtask

  initial begin
    rst        = 1'b1;
    seed_write = 1'b0;
    seed_data  = '0;
    in_valid   = 1'b0;
    range_low  = '0;
    range_high = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_ranges();
    test_seed_extremes();
    test_long_rejection();
    test_backpressure();
    test_random_ranges();

    // Let stragglers show up before the verdict
    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Result side: long hold-offs on request, otherwise random stall bursts
  always @(negedge clk) begin
    if (hold_requests_served != hold_requests_made) begin
      hold_requests_served = hold_requests_made;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left > 0) begin
      out_stall = 1'b1;
      rx_hold_left = rx_hold_left - 1;
    end else if (rx_burst_left > 0) begin
      out_stall = 1'b1;
      rx_burst_left = rx_burst_left - 1;
    end else if (idle_enable && $urandom_range(0, 9) == 0) begin
      out_stall = 1'b1;
      rx_burst_left = $urandom_range(1, 17) - 1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each result transfer against the oldest logged request
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= 10) begin
          $display("unexpected result: value %h error %b", value, range_error);
        end
      end else begin
        oldest_result = expected_results.pop_front();
        if (value !== oldest_result.value || range_error !== oldest_result.range_error) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10) begin
            $display("mismatch [%h, %h]: expected %h/%b, got %h/%b",
                     oldest_result.req_low, oldest_result.req_high, oldest_result.value,
                     oldest_result.range_error, value, range_error);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
